FILE: hdl/rgb565_upscale_3to4_vblend_core_assert.svh
// Assertion macros for the upscaler core
`ifndef RGB565_UPSCALE_3TO4_VBLEND_CORE_ASSERT_SVH
`define RGB565_UPSCALE_3TO4_VBLEND_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RGBUP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication, disabled in reset
`define RGBUP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: hdl/rgbup_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rgbup_pkg;

    localparam int GROUPS_PER_ROW_DEF = 80;

    localparam logic [7:0] SOURCE_ROWS_RESET = 8'd208;
    localparam logic [7:0] OUTPUT_ROWS_RESET = 8'd240;
    localparam logic [8:0] START_ROW_RESET   = 9'd8;

    localparam logic [15:0] MEAN_CARRY_MASK = 16'h0821;

    localparam int          APB_ADDR_W      = 4;
    localparam int          APB_DATA_W      = 32;
    localparam logic [1:0]  REG_SOURCE_ROWS = 2'd0;
    localparam logic [1:0]  REG_OUTPUT_ROWS = 2'd1;
    localparam logic [1:0]  REG_START_ROW   = 2'd2;

    typedef struct packed {
        logic [15:0] upper_left;
        logic [15:0] upper_mid;
        logic [15:0] upper_right;
        logic [15:0] lower_left;
        logic [15:0] lower_mid;
        logic [15:0] lower_right;
    } in_word_t;

    typedef struct packed {
        logic [15:0] pix0;
        logic [15:0] pix1;
        logic [15:0] pix2;
        logic [15:0] pix3;
        logic [9:0]  next_source_row;
        logic        row_done;
        logic        frame_done;
    } out_word_t;

    typedef struct packed {
        logic [9:0] next_source_row;
        logic       row_done;
        logic       frame_done;
    } seq_info_t;

    function automatic logic [15:0] mean565(input logic [15:0] p, input logic [15:0] q);
        logic [16:0] sum;
        sum = {1'b0, p} + {1'b0, q} + {1'b0, (p ^ q) & MEAN_CARRY_MASK};
        return sum[16:1];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/rgbup_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module rgbup_lane
    import rgbup_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic        blend,
    input  wire logic [15:0] upper,
    input  wire logic [15:0] lower,
    output logic      [15:0] pix_reg
);

    logic [15:0] pix_next;

    always_comb begin
        pix_next = blend ? mean565(upper, lower) : upper;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg <= pix_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rgbup_merge.sv
`timescale 1ns / 1ps
`default_nettype none
module rgbup_merge
    import rgbup_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      en,
    input  wire logic [15:0] pix_a,
    input  wire logic [15:0] pix_b,
    input  wire logic [15:0] pix_c,
    input  wire seq_info_t info,
    output out_word_t      out_reg
);

    out_word_t   out_next;
    logic [15:0] mean_ab;
    logic [15:0] mean_bc;

    always_comb begin
        mean_ab                  = mean565(pix_a, pix_b);
        mean_bc                  = mean565(pix_b, pix_c);
        out_next.pix0            = pix_a;
        out_next.pix1            = {pix_b[15:5], mean_ab[4:0]};
        out_next.pix2            = {mean_bc[15:11], pix_b[10:0]};
        out_next.pix3            = pix_c;
        out_next.next_source_row = info.next_source_row;
        out_next.row_done        = info.row_done;
        out_next.frame_done      = info.frame_done;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rgbup_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module rgbup_seq
    import rgbup_pkg::*;
#(
    parameter int GROUPS_PER_ROW = GROUPS_PER_ROW_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] source_rows,
    input  wire logic [7:0] output_rows,
    input  wire logic [8:0] start_row,
    output logic            blend,
    output seq_info_t       info
);

    localparam int GW = (GROUPS_PER_ROW > 1) ? $clog2(GROUPS_PER_ROW) : 1;
    localparam logic [GW:0] GROUPS_LIMIT = (GW + 1)'(GROUPS_PER_ROW);

    logic [7:0]    acc_reg,   acc_next;
    logic [9:0]    src_reg,   src_next;
    logic          blend_reg, blend_next;
    logic [GW-1:0] group_reg, group_next;
    logic [7:0]    orow_reg,  orow_next;

    logic [8:0]    modulus;
    logic [8:0]    acc_sum;
    logic [8:0]    acc_sub;
    logic [8:0]    orow_inc;
    logic          row_end;
    logic          frame_end;

    always_comb begin
        modulus    = {(output_rows == 8'd0), output_rows};
        acc_sum    = {1'b0, acc_reg} + {1'b0, source_rows};
        acc_sub    = acc_sum - modulus;
        orow_inc   = {1'b0, orow_reg} + 9'd1;
        row_end    = (({1'b0, group_reg} + (GW + 1)'(1)) >= GROUPS_LIMIT);
        frame_end  = 1'b0;
        acc_next   = acc_reg;
        src_next   = src_reg;
        blend_next = blend_reg;
        orow_next  = orow_reg;
        group_next = group_reg + GW'(1);
        if (row_end) begin
            group_next = '0;
            if (acc_sum >= modulus) begin
                acc_next   = (acc_sub >= modulus) ? 8'(modulus - 9'd1) : acc_sub[7:0];
                src_next   = src_reg + 10'd1;
                blend_next = 1'b0;
            end else begin
                acc_next   = acc_sum[7:0];
                blend_next = 1'b1;
            end
            orow_next = orow_inc[7:0];
            if (orow_inc >= modulus) begin
                frame_end  = 1'b1;
                orow_next  = '0;
                acc_next   = '0;
                blend_next = 1'b0;
                src_next   = {1'b0, start_row};
            end
        end
        blend                = blend_reg;
        info.next_source_row = src_next;
        info.row_done        = row_end;
        info.frame_done      = frame_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            src_reg   <= {1'b0, START_ROW_RESET};
            blend_reg <= 1'b0;
            group_reg <= '0;
            orow_reg  <= '0;
        end else if (step) begin
            acc_reg   <= acc_next;
            src_reg   <= src_next;
            blend_reg <= blend_next;
            group_reg <= group_next;
            orow_reg  <= orow_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rgb565_upscale_3to4_vblend_core.sv
// An accepted input word is registered in the three lane registers, then in the merge register.
// Throughput: one word per cycle while the output is not stalled; three blend lanes feed one merge register.
// Output stall backs up through the two stages; input stays ready while a stage is free.
// Reset (aresetn low, synchronous): pipeline empties, counters and accumulator clear,
// source row and registers return to their defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb565_upscale_3to4_vblend_core_assert.svh"
module rgb565_upscale_3to4_vblend_core
    import rgbup_pkg::*;
#(
    parameter int GROUPS_PER_ROW = GROUPS_PER_ROW_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [7:0] source_rows_reg;
    logic [7:0] output_rows_reg;
    logic [8:0] start_row_reg;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    logic       v1_reg;
    logic       v2_reg;
    logic       adv1;
    logic       take;
    logic       blend;
    seq_info_t  info;
    seq_info_t  info1_reg;
    logic [15:0] pix_a_reg;
    logic [15:0] pix_b_reg;
    logic [15:0] pix_c_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        case (cfg_idx)
            REG_SOURCE_ROWS: prdata = {24'd0, source_rows_reg};
            REG_OUTPUT_ROWS: prdata = {24'd0, output_rows_reg};
            REG_START_ROW:   prdata = {23'd0, start_row_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_rows_reg <= SOURCE_ROWS_RESET;
            output_rows_reg <= OUTPUT_ROWS_RESET;
            start_row_reg   <= START_ROW_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SOURCE_ROWS: source_rows_reg <= pwdata[7:0];
                REG_OUTPUT_ROWS: output_rows_reg <= pwdata[7:0];
                REG_START_ROW:   start_row_reg   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    assign adv1    = !v2_reg || m_ready;
    assign s_ready = !v1_reg || adv1;
    assign take    = s_valid && s_ready;
    assign m_valid = v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                v1_reg <= take;
            end
            if (adv1) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            info1_reg <= info;
        end
    end

    rgbup_seq #(
        .GROUPS_PER_ROW(GROUPS_PER_ROW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (take),
        .source_rows (source_rows_reg),
        .output_rows (output_rows_reg),
        .start_row   (start_row_reg),
        .blend       (blend),
        .info        (info)
    );

    rgbup_lane u_lane_a (
        .aclk    (aclk),
        .en      (take),
        .blend   (blend),
        .upper   (s_data.upper_left),
        .lower   (s_data.lower_left),
        .pix_reg (pix_a_reg)
    );

    rgbup_lane u_lane_b (
        .aclk    (aclk),
        .en      (take),
        .blend   (blend),
        .upper   (s_data.upper_mid),
        .lower   (s_data.lower_mid),
        .pix_reg (pix_b_reg)
    );

    rgbup_lane u_lane_c (
        .aclk    (aclk),
        .en      (take),
        .blend   (blend),
        .upper   (s_data.upper_right),
        .lower   (s_data.lower_right),
        .pix_reg (pix_c_reg)
    );

    rgbup_merge u_merge (
        .aclk    (aclk),
        .en      (adv1 && v1_reg),
        .pix_a   (pix_a_reg),
        .pix_b   (pix_b_reg),
        .pix_c   (pix_c_reg),
        .info    (info1_reg),
        .out_reg (m_data)
    );

    `RGBUP_ASSERT_SAME(a_frame_ends_row, aclk, aresetn, m_valid && m_data.frame_done, m_data.row_done)
    `RGBUP_ASSERT_SAME(a_full_blocks_input, aclk, aresetn, v1_reg && v2_reg && !m_ready, !s_ready)
    `RGBUP_ASSERT_NEXT(a_take_fills_stage, aclk, aresetn, take, v1_reg)

endmodule
`default_nettype wire

FILE: dv/rgb565_upscale_3to4_vblend_core_tb.sv
`timescale 1ns / 1ps

class upscale_scoreboard;
    localparam int ROW_GROUPS = rgbup_pkg::GROUPS_PER_ROW_DEF;

    logic [7:0] src_rows;
    logic [7:0] out_rows;
    logic [8:0] first_row;

    logic [7:0] row_acc;
    logic [9:0] src_row;
    logic       blend;
    logic [6:0] group_idx;
    logic [7:0] out_row_idx;

    rgbup_pkg::out_word_t expected_words[$];
    int fail_count;

    function new();
        src_rows    = rgbup_pkg::SOURCE_ROWS_RESET;
        out_rows    = rgbup_pkg::OUTPUT_ROWS_RESET;
        first_row   = rgbup_pkg::START_ROW_RESET;
        row_acc     = '0;
        src_row     = {1'b0, first_row};
        blend       = 1'b0;
        group_idx   = '0;
        out_row_idx = '0;
        fail_count  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
        case (idx)
            rgbup_pkg::REG_SOURCE_ROWS: src_rows  = value[7:0];
            rgbup_pkg::REG_OUTPUT_ROWS: out_rows  = value[7:0];
            rgbup_pkg::REG_START_ROW:   first_row = value[8:0];
            default: ;
        endcase
    endfunction

    function logic [15:0] avg565(logic [15:0] p, logic [15:0] q);
        logic [16:0] sum;
        sum = {1'b0, p} + {1'b0, q} + {1'b0, (p ^ q) & rgbup_pkg::MEAN_CARRY_MASK};
        return sum[16:1];
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    // advance the line state and queue the group this word produces
    function void note_input(rgbup_pkg::in_word_t w);
        logic [15:0] a, b, c, ab, bc;
        logic [8:0]  modulus, acc_sum, row_next;
        rgbup_pkg::out_word_t r;
        modulus = (out_rows == 8'd0) ? 9'd256 : {1'b0, out_rows};
        a = w.upper_left;
        b = w.upper_mid;
        c = w.upper_right;
        if (blend) begin
            a = avg565(a, w.lower_left);
            b = avg565(b, w.lower_mid);
            c = avg565(c, w.lower_right);
        end
        ab = avg565(a, b);
        bc = avg565(b, c);
        r.pix0       = a;
        r.pix1       = {b[15:5], ab[4:0]};
        r.pix2       = {bc[15:11], b[10:0]};
        r.pix3       = c;
        r.row_done   = 1'b0;
        r.frame_done = 1'b0;
        if (int'(group_idx) + 1 >= ROW_GROUPS) begin
            r.row_done = 1'b1;
            group_idx  = '0;
            acc_sum    = {1'b0, row_acc} + {1'b0, src_rows};
            if (acc_sum >= modulus) begin
                acc_sum = acc_sum - modulus;
                if (acc_sum >= modulus)
                    acc_sum = modulus - 9'd1;
                src_row = src_row + 10'd1;
                blend   = 1'b0;
            end else begin
                blend = 1'b1;
            end
            row_acc  = acc_sum[7:0];
            row_next = {1'b0, out_row_idx} + 9'd1;
            if (row_next >= modulus) begin
                r.frame_done = 1'b1;
                out_row_idx  = '0;
                row_acc      = '0;
                blend        = 1'b0;
                src_row      = {1'b0, first_row};
            end else begin
                out_row_idx = row_next[7:0];
            end
        end else begin
            group_idx = group_idx + 7'd1;
        end
        r.next_source_row = src_row;
        expected_words.push_back(r);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        fail_count++;
        if (fail_count <= 100)
            $display("ERROR %s: got %h, expected %h", what, got, want);
    endtask

    task check_result(rgbup_pkg::out_word_t got);
        rgbup_pkg::out_word_t want;
        if (expected_words.size() == 0) begin
            report("word with nothing pending, pix0", got.pix0, 16'h0);
        end else begin
            want = expected_words.pop_front();
            if (got.pix0 !== want.pix0)
                report("pix0", got.pix0, want.pix0);
            if (got.pix1 !== want.pix1)
                report("pix1", got.pix1, want.pix1);
            if (got.pix2 !== want.pix2)
                report("pix2", got.pix2, want.pix2);
            if (got.pix3 !== want.pix3)
                report("pix3", got.pix3, want.pix3);
            if (got.next_source_row !== want.next_source_row)
                report("next_source_row", 16'(got.next_source_row),
                       16'(want.next_source_row));
            if (got.row_done !== want.row_done)
                report("row_done", 16'(got.row_done), 16'(want.row_done));
            if (got.frame_done !== want.frame_done)
                report("frame_done", 16'(got.frame_done), 16'(want.frame_done));
        end
    endtask
endclass

module rgb565_upscale_3to4_vblend_core_tb;
    import rgbup_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    upscale_scoreboard sb;
    bit calm = 1'b0;
    int quiet_cycles = 0;

    rgb565_upscale_3to4_vblend_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_word(input in_word_t w);
        while (!calm && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(w);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_pixel();
        logic [15:0] p;
        case ($urandom_range(0, 9))
            0:       p = 16'h0000;
            1:       p = 16'hFFFF;
            2:       p = 16'hF800;
            3:       p = 16'h07E0;
            4:       p = 16'h001F;
            5:       p = 16'h0821;
            6:       p = 16'h1 << $urandom_range(0, 15);
            default: p = 16'($urandom);
        endcase
        return p;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        w.upper_left  = pick_pixel();
        w.upper_mid   = pick_pixel();
        w.upper_right = pick_pixel();
        w.lower_left  = pick_pixel();
        w.lower_mid   = pick_pixel();
        w.lower_right = pick_pixel();
        return w;
    endfunction

    // drain, reprogram, then stream random triples
    task automatic run_phase(input int n, input logic [7:0] srcr, input logic [7:0] outr,
                             input logic [8:0] firstr, input bit no_idle);
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        write_reg(REG_SOURCE_ROWS, 32'(srcr));
        write_reg(REG_OUTPUT_ROWS, 32'(outr));
        write_reg(REG_START_ROW, 32'(firstr));
        calm = no_idle;
        repeat (n) send_word(random_word());
        calm = 1'b0;
    endtask

    initial begin
        logic [15:0] dir_pix[10];
        in_word_t w;
        sb = new();
        dir_pix = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F,
                    16'hAAAA, 16'h5555, 16'h0821, 16'hF7DE, 16'h8410};
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < 10; i++) begin
            w = '{dir_pix[i], dir_pix[i], dir_pix[i],
                  dir_pix[9 - i], dir_pix[9 - i], dir_pix[9 - i]};
            send_word(w);
        end
        send_word('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
        send_word('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
        send_word('{16'hF800, 16'h07E0, 16'h001F, 16'h001F, 16'hF800, 16'h07E0});
        send_word('{16'h001F, 16'hF800, 16'h07E0, 16'h07E0, 16'h001F, 16'hF800});
        send_word('{16'h0821, 16'h0000, 16'h0821, 16'h0000, 16'h0821, 16'h0000});
        send_word('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        repeat (220) send_word(random_word());

        run_phase(160, 8'd1,   8'd3,   9'd0,   1'b0);
        run_phase(160, 8'd255, 8'd1,   9'd511, 1'b0);
        run_phase(200, 8'd0,   8'd0,   9'd300, 1'b0);
        run_phase(240, 8'd3,   8'd2,   9'd1,   1'b1);
        run_phase(200, 8'd7,   8'd5,   9'h155, 1'b0);
        run_phase(160, 8'd200, 8'd255, 9'h0AA, 1'b0);
        repeat (3)
            run_phase(160, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 8)),
                      9'($urandom_range(0, 511)), 1'b0);

        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: rgb565_upscale_3to4_vblend_core.f
+incdir+hdl
hdl/rgbup_pkg.sv
hdl/rgbup_lane.sv
hdl/rgbup_merge.sv
hdl/rgbup_seq.sv
hdl/rgb565_upscale_3to4_vblend_core.sv
dv/rgb565_upscale_3to4_vblend_core_tb.sv
